[rtl/core/positional_ordered_list_store_assert.svh]
// Assertion macros shared by the list store RTL.
// Each macro takes a label, a condition sampled at a clock edge, the property
// that must follow from it and a message. Reset disables the check.
`ifndef POSITIONAL_ORDERED_LIST_STORE_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_STORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define POLS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define POLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pols_pkg.sv]
package pols_pkg;

  // Command codes carried on the kind field.
  typedef enum logic [2:0] {
    K_INS_FRONT = 3'd0,
    K_INS_POS   = 3'd1,
    K_DEL_FRONT = 3'd2,
    K_DEL_END   = 3'd3,
    K_DEL_POS   = 3'd4,
    K_UPDATE    = 3'd5,
    K_READOUT   = 3'd6,
    K_UNUSED    = 3'd7
  } kind_e;

  // Status codes carried on every result.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_READ_RD,
    S_READ_OUT
  } state_e;

  // Direction in which a shift moves the entries.
  typedef enum logic [0:0] {
    DIR_DOWN = 1'b0,
    DIR_UP   = 1'b1
  } dir_e;

endpackage

[rtl/core/positional_ordered_list_store.sv]
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+-----------------------------------------
// in      | to block  | in_valid_i / in_stall_o | kind_i, value_i, search_key_i, position_i
// out     | from block| out_valid_o/ out_stall_i| status_o, item_value_o, last_o
//
// One request at a time; in_stall_o is high from the cycle after a known request is taken
// until its sequence ends, as the single memory port moves one entry per cycle.
// A rejected request or a delete at the end only delivers a status; inserts and deletes
// move entries as needed, an update compares entries in turn, a readout delivers each entry.
// Reset clears the count, the sequencer, the write-back flag and the output valid only.
// An output stall holds the sequencer where it is about to load a result.
`include "positional_ordered_list_store_assert.svh"

module positional_ordered_list_store
  import pols_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] search_key_i,
  input  logic [7:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] item_value_o,
  output logic               last_o
);

  // Width of the entry count (holds DEPTH itself) and of a memory index.
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  // Width in which positions and counts are compared without overflow.
  localparam int CmpW = ((CW > 8) ? CW : 8) + 1;
  localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

  // The list itself: entry 0 is the front. One write and one registered read
  // per cycle.
  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rd_data_q;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  // Sequencer and its working registers.
  state_e             state_q, state_d, dec_next;
  logic [CW-1:0]      count_q, count_d;
  logic [IW-1:0]      src_q, src_d;     // entry being read
  logic [IW-1:0]      end_q, end_d;     // last entry to read during a shift
  logic [IW-1:0]      tgt_q, tgt_d;     // slot for an inserted value
  dir_e               dir_q, dir_d;
  status_e            st_q, st_d;
  logic signed [31:0] value_q, value_d;
  logic signed [31:0] key_q, key_d;

  // A moved entry is written back the cycle after it is read.
  logic               pend_q, pend_d;
  logic [IW-1:0]      pw_addr_q, pw_addr_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic signed [31:0] item_value_q, item_value_d;
  logic               last_q, last_d;
  logic               out_load;
  logic               out_free;

  logic               in_acc;
  logic               is_empty;
  logic               is_full;
  logic [IW-1:0]      cnt_last;
  logic [CmpW-1:0]    pos_ext;
  logic [CmpW-1:0]    cnt_ext;
  logic               scan_hit;
  logic               at_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == DepthCnt);
  assign cnt_last = IW'(count_q - 1'b1);
  assign pos_ext  = CmpW'(position_i);
  assign cnt_ext  = CmpW'(count_q);
  assign scan_hit = (rd_data_q == key_q);
  assign at_last  = (src_q == cnt_last);

  // Request decode: where the sequencer goes and what it latches when a
  // request is taken. Position checks come before the full check for a positional
  // insert, but after the empty check for a positional delete.
  always_comb begin
    dec_next = S_IDLE;
    count_d  = count_q;
    src_d    = src_q;
    end_d    = end_q;
    tgt_d    = tgt_q;
    dir_d    = dir_q;
    st_d     = st_q;
    value_d  = value_q;
    key_d    = key_q;
    if (in_acc) begin
      value_d = value_i;
      key_d   = search_key_i;
      st_d    = ST_OK;
      dec_next = S_IDLE;
      unique case (kind_i)
        K_INS_FRONT: begin
          if (is_full) begin
            st_d     = ST_FULL;
            dec_next = S_IDLE;
          end else begin
            count_d = count_q + 1'b1;
            tgt_d   = '0;
            src_d   = cnt_last;
            end_d   = '0;
            dir_d   = DIR_UP;
            dec_next = is_empty ? S_PUT : S_SHIFT;
          end
        end
        K_INS_POS: begin
          if (position_i == '0 || pos_ext > cnt_ext + 1'b1) begin
            st_d = ST_BADPOS;
          end else if (is_full) begin
            st_d = ST_FULL;
          end else begin
            count_d = count_q + 1'b1;
            tgt_d   = IW'(position_i - 8'd1);
            src_d   = cnt_last;
            end_d   = IW'(position_i - 8'd1);
            dir_d   = DIR_UP;
            // Appending behind the last entry moves nothing.
            dec_next = (pos_ext == cnt_ext + 1'b1) ? S_PUT : S_SHIFT;
          end
        end
        K_DEL_FRONT: begin
          if (is_empty) begin
            st_d = ST_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
            src_d   = IW'(1);
            end_d   = cnt_last;
            dir_d   = DIR_DOWN;
            dec_next = (count_q == CW'(1)) ? S_IDLE : S_SHIFT;
          end
        end
        K_DEL_END: begin
          if (is_empty) begin
            st_d = ST_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        K_DEL_POS: begin
          if (is_empty) begin
            st_d = ST_EMPTY;
          end else if (position_i == '0 || pos_ext > cnt_ext) begin
            st_d = ST_BADPOS;
          end else begin
            count_d = count_q - 1'b1;
            src_d   = IW'(position_i);
            end_d   = cnt_last;
            dir_d   = DIR_DOWN;
            // Removing the last entry moves nothing.
            dec_next = (pos_ext == cnt_ext) ? S_IDLE : S_SHIFT;
          end
        end
        K_UPDATE: begin
          if (is_empty) begin
            st_d = ST_NOTFOUND;
          end else begin
            src_d    = '0;
            dec_next = S_SCAN_RD;
          end
        end
        K_READOUT: begin
          if (is_empty) begin
            st_d = ST_EMPTY;
          end else begin
            src_d    = '0;
            dec_next = S_READ_RD;
          end
        end
        default: begin
          dec_next = S_IDLE;
        end
      endcase
    end else begin
      unique case (state_q)
        S_SHIFT: begin
          if (src_q != end_q) begin
            src_d = (dir_q == DIR_UP) ? IW'(src_q - 1'b1) : IW'(src_q + 1'b1);
          end
        end
        S_SCAN_CMP: begin
          if (scan_hit) begin
            st_d = ST_OK;
          end else if (at_last) begin
            st_d = ST_NOTFOUND;
          end else begin
            src_d = IW'(src_q + 1'b1);
          end
        end
        S_READ_OUT: begin
          if (out_free && !at_last) begin
            src_d = IW'(src_q + 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The unused command code is dropped without a result.
  logic kind_known;

  assign kind_known = (kind_i != K_UNUSED);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = dec_next;
          // Requests that finish at once leave a status to deliver.
          if (dec_next == S_IDLE && kind_known) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_SHIFT: begin
        if (src_q == end_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (dir_q == DIR_UP && pend_q) begin
          state_d = S_PUT;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_PUT: begin
        state_d = S_DRAIN;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        state_d = (scan_hit || at_last) ? S_DRAIN : S_SCAN_RD;
      end
      S_READ_RD: begin
        state_d = S_READ_OUT;
      end
      S_READ_OUT: begin
        if (out_free) begin
          state_d = at_last ? S_IDLE : S_READ_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Memory port control, write-back pipeline and output register loads.
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = src_q;
    wr_en        = 1'b0;
    wr_addr      = pw_addr_q;
    wr_data      = rd_data_q;
    pend_d       = 1'b0;
    pw_addr_d    = pw_addr_q;
    out_load     = 1'b0;
    status_d     = status_q;
    item_value_d = item_value_q;
    last_d       = last_q;

    if (pend_q) begin
      wr_en = 1'b1;
    end

    unique case (state_q)
      S_SHIFT: begin
        rd_en     = 1'b1;
        pend_d    = 1'b1;
        pw_addr_d = (dir_q == DIR_UP) ? IW'(src_q + 1'b1) : IW'(src_q - 1'b1);
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = tgt_q;
        wr_data = value_q;
      end
      S_DRAIN: begin
        // The status is loaded once the output is free, at the earliest together with the last
        // moved entry's write, except for an insert, which must first put the new value in place.
        if (!(dir_q == DIR_UP && pend_q) && out_free) begin
          out_load     = 1'b1;
          status_d     = st_q;
          item_value_d = '0;
          last_d       = 1'b1;
        end
      end
      S_SCAN_RD, S_READ_RD: begin
        rd_en = 1'b1;
      end
      S_SCAN_CMP: begin
        if (scan_hit) begin
          wr_en   = 1'b1;
          wr_addr = src_q;
          wr_data = value_q;
        end
      end
      S_READ_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          status_d     = ST_OK;
          item_value_d = rd_data_q;
          last_d       = at_last;
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers, no reset needed.
  always_ff @(posedge clk_i) begin
    src_q        <= src_d;
    end_q        <= end_d;
    tgt_q        <= tgt_d;
    dir_q        <= dir_d;
    st_q         <= st_d;
    value_q      <= value_d;
    key_q        <= key_d;
    pw_addr_q    <= pw_addr_d;
    status_q     <= status_d;
    item_value_q <= item_value_d;
    last_q       <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign item_value_o = item_value_q;
  assign last_o       = last_q;

  // The count never runs past the capacity of the store.
  `POLS_ASSERT_SAME(a_count_range, 1'b1, count_q <= DepthCnt, "entry count above depth")
  // A result is only loaded into a free output register.
  `POLS_ASSERT_SAME(a_load_free, out_load, !out_valid_q || !out_stall_i,
                    "result overwrote a pending result")
  // No entry is still being moved once the block takes a new request.
  `POLS_ASSERT_SAME(a_idle_no_pend, !in_stall_o, !pend_q, "write-back pending while idle")
  // A successful front insert grows the list by one entry.
  `POLS_ASSERT_NEXT(a_ins_grow, in_acc && kind_i == K_INS_FRONT && !is_full,
                    count_q == $past(count_q) + 1'b1, "front insert did not grow the list")

endmodule
